// ----- sv/kcm_pkg.sv -----
package kcm_pkg;

  localparam logic [2:0] CMD_DONGLE  = 3'd0;
  localparam logic [2:0] CMD_KEY     = 3'd1;
  localparam logic [2:0] CMD_UNKNOWN = 3'd2;
  localparam logic [2:0] CMD_ADD     = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_TRIGGER = 3'd5;
  localparam logic [2:0] CMD_TICK    = 3'd6;
  localparam logic [2:0] CMD_COUNT   = 3'd7;

  localparam logic [2:0] EV_CODE_RX    = 3'd0;
  localparam logic [2:0] EV_MATCH      = 3'd1;
  localparam logic [2:0] EV_INCORRECT  = 3'd2;
  localparam logic [2:0] EV_TABLE_FULL = 3'd3;
  localparam logic [2:0] EV_COUNT      = 3'd4;

  localparam logic [31:0] KEY_CANCEL     = 32'h1B;
  localparam logic [31:0] KEY_SUBMIT     = 32'hD;
  localparam logic [3:0]  DIGIT_BASE     = 4'd10;
  localparam logic [15:0] MASK_INCORRECT = 16'hFFFF;
  localparam logic [7:0]  TYPE_DONGLE    = 8'd0;
  localparam logic [7:0]  TYPE_DIGIT     = 8'd1;

  localparam logic [0:0] REG_TIMEOUT    = 1'b0;
  localparam logic [0:0] REG_MAX_DIGITS = 1'b1;

  // Work item handed from front to back.
  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,  // report, scan, match/incorrect
    OP_EMIT  = 2'd1   // single result
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  kind;
    logic        to_req;
    logic [7:0]  dest;
    logic [31:0] code;
    logic [7:0]  ctype;
    logic [15:0] mask;
    logic [4:0]  count;
  } job_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic        to_requester;
    logic [7:0]  dest_id;
    logic [31:0] reported_code;
    logic [7:0]  reported_type;
    logic [15:0] button_mask;
    logic [4:0]  entry_count;
    logic        last;
  } result_t;

endpackage

// ----- sv/kcm_if.sv -----
interface kcm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] key_code;
  logic [7:0]  code_type;
  logic [15:0] button_bitmap;
  logic [7:0]  requester_id;
  modport source (output valid, command, key_code, code_type, button_bitmap, requester_id,
                  input ready);
  modport sink (input valid, command, key_code, code_type, button_bitmap, requester_id,
                output ready);
endinterface

interface kcm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic        to_requester;
  logic [7:0]  dest_id;
  logic [31:0] reported_code;
  logic [7:0]  reported_type;
  logic [15:0] button_mask;
  logic [4:0]  entry_count;
  logic        last;
  modport source (output valid, event_kind, to_requester, dest_id, reported_code,
                  reported_type, button_mask, entry_count, last, input ready);
  modport sink (input valid, event_kind, to_requester, dest_id, reported_code,
                reported_type, button_mask, entry_count, last, output ready);
endinterface

interface kcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/kcm_ram.sv -----
module kcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/kcm_front.sv -----
module kcm_front #(
  parameter int TABLE_DEPTH = 16,
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  kcm_in_if.sink                       in_ch,
  kcm_cfg_if.sink                      cfg_ch,
  output logic                         job_valid,
  output kcm_pkg::job_t                job,
  input  logic                         job_full,
  input  logic                         back_busy,
  output logic                         tab_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] tab_waddr,
  output logic [55:0]                  tab_wdata,
  output logic [CW-1:0]                entries_used
);
  import kcm_pkg::*;

  logic [CW-1:0] used_r, used_nxt;
  logic [31:0]   pend_val_r, pend_val_nxt;
  logic [3:0]    pend_dig_r, pend_dig_nxt;
  logic [15:0]   ticks_r, ticks_nxt;
  logic          armed_r, armed_nxt;
  logic [15:0]   timeout_r;
  logic [3:0]    max_dig_r;
  logic [35:0]   times_ten;
  logic          acc;
  logic          full_tab;

  // Hold table updates until the job queue is empty and the back is idle.
  assign in_ch.ready  = !job_full &&
                        !(back_busy && (in_ch.command inside {CMD_ADD, CMD_CLEAR}));
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && in_ch.ready;
  assign entries_used = used_r;
  assign full_tab     = used_r >= CW'(TABLE_DEPTH);
  assign times_ten    = pend_val_r * DIGIT_BASE;

  assign tab_waddr = used_r[$clog2(TABLE_DEPTH)-1:0];
  assign tab_wdata = {in_ch.code_type, in_ch.key_code, in_ch.button_bitmap};

  always_comb begin
    used_nxt     = used_r;
    pend_val_nxt = pend_val_r;
    pend_dig_nxt = pend_dig_r;
    ticks_nxt    = ticks_r;
    armed_nxt    = armed_r;
    job_valid    = 1'b0;
    job          = '0;
    tab_we       = 1'b0;
    if (acc) begin
      case (in_ch.command)
        CMD_DONGLE: begin
          job_valid = 1'b1;
          job.op    = OP_CHECK;
          job.code  = in_ch.key_code;
          job.ctype = TYPE_DONGLE;
          {armed_nxt, ticks_nxt, pend_dig_nxt, pend_val_nxt} = '0;
        end
        CMD_KEY: begin
          armed_nxt = 1'b1;
          ticks_nxt = timeout_r;
          if (in_ch.key_code == KEY_CANCEL) begin
            {armed_nxt, ticks_nxt, pend_dig_nxt, pend_val_nxt} = '0;
          end else if (in_ch.key_code == KEY_SUBMIT) begin
            job_valid = 1'b1;
            job.op    = OP_CHECK;
            job.code  = pend_val_r;
            job.ctype = TYPE_DIGIT;
            {armed_nxt, ticks_nxt, pend_dig_nxt, pend_val_nxt} = '0;
          end else if (pend_dig_r >= max_dig_r) begin
            job_valid = 1'b1;
            job.op    = OP_EMIT;
            job.kind  = EV_INCORRECT;
            job.mask  = MASK_INCORRECT;
            {armed_nxt, ticks_nxt, pend_dig_nxt, pend_val_nxt} = '0;
          end else begin
            pend_val_nxt = times_ten[31:0] + in_ch.key_code;
            pend_dig_nxt = pend_dig_r + 4'd1;
          end
        end
        CMD_UNKNOWN: begin
          {armed_nxt, ticks_nxt, pend_dig_nxt, pend_val_nxt} = '0;
        end
        CMD_ADD: begin
          if (full_tab) begin
            job_valid  = 1'b1;
            job.op     = OP_EMIT;
            job.kind   = EV_TABLE_FULL;
            job.to_req = 1'b1;
            job.dest   = in_ch.requester_id;
          end else begin
            tab_we   = 1'b1;
            used_nxt = used_r + CW'(1);
          end
        end
        CMD_CLEAR: used_nxt = '0;
        CMD_TRIGGER: begin
          job_valid = 1'b1;
          job.op    = OP_CHECK;
          job.code  = in_ch.key_code;
          job.ctype = in_ch.code_type;
        end
        CMD_TICK: begin
          if (armed_r) begin
            if (ticks_r <= 16'd1) begin
              job_valid = 1'b1;
              job.op    = OP_EMIT;
              job.kind  = EV_INCORRECT;
              job.mask  = MASK_INCORRECT;
              {armed_nxt, ticks_nxt, pend_dig_nxt, pend_val_nxt} = '0;
            end else begin
              ticks_nxt = ticks_r - 16'd1;
            end
          end
        end
        default: begin
          job_valid  = 1'b1;
          job.op     = OP_EMIT;
          job.kind   = EV_COUNT;
          job.to_req = 1'b1;
          job.dest   = in_ch.requester_id;
          job.count  = 5'(used_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      pend_val_r <= '0;
      pend_dig_r <= '0;
      ticks_r    <= '0;
      armed_r    <= 1'b0;
      timeout_r  <= 16'd3000;
      max_dig_r  <= 4'd8;
    end else begin
      used_r     <= used_nxt;
      pend_val_r <= pend_val_nxt;
      pend_dig_r <= pend_dig_nxt;
      ticks_r    <= ticks_nxt;
      armed_r    <= armed_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_TIMEOUT:    timeout_r <= cfg_ch.data;
          REG_MAX_DIGITS: max_dig_r <= cfg_ch.data[3:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- sv/kcm_back.sv -----
module kcm_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  kcm_pkg::job_t                  job,
  output logic                           job_taken,
  output logic                           busy,
  output logic [$clog2(TABLE_DEPTH)-1:0] tab_raddr,
  input  logic [55:0]                    tab_rdata,
  input  logic [CW-1:0]                  entries_used,
  kcm_out_if.source                      out_ch
);
  import kcm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REPORT = 5'b00010,
    S_READ   = 5'b00100,
    S_CMP    = 5'b01000,
    S_FINAL  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  job_t          job_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt;
  logic [15:0]   mask_r, mask_nxt;
  result_t       res;
  logic          hit;

  assign tab_raddr = idx_r[$clog2(TABLE_DEPTH)-1:0];
  assign job_taken = (state_r == S_IDLE) && job_valid;
  assign busy      = state_r != S_IDLE;
  assign hit = (tab_rdata[55:48] == job_r.ctype) && (tab_rdata[47:16] == job_r.code);

  always_comb begin
    res = '0;
    case (state_r)
      S_REPORT: begin
        res.event_kind    = EV_CODE_RX;
        res.reported_code = job_r.code;
        res.reported_type = job_r.ctype;
      end
      S_FINAL: begin
        if (job_r.op == OP_EMIT) begin
          res.event_kind   = job_r.kind;
          res.to_requester = job_r.to_req;
          res.dest_id      = job_r.dest;
          res.button_mask  = job_r.mask;
          res.entry_count  = job_r.count;
        end else if (hit_r) begin
          res.event_kind  = EV_MATCH;
          res.button_mask = mask_r;
        end else begin
          res.event_kind  = EV_INCORRECT;
          res.button_mask = MASK_INCORRECT;
        end
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = (state_r == S_REPORT) || (state_r == S_FINAL);
  assign out_ch.event_kind    = res.event_kind;
  assign out_ch.to_requester  = res.to_requester;
  assign out_ch.dest_id       = res.dest_id;
  assign out_ch.reported_code = res.reported_code;
  assign out_ch.reported_type = res.reported_type;
  assign out_ch.button_mask   = res.button_mask;
  assign out_ch.entry_count   = res.entry_count;
  assign out_ch.last          = res.last;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    mask_nxt  = mask_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        hit_nxt = 1'b0;
        if (job_valid) begin
          state_nxt = (job.op == OP_CHECK) ? S_REPORT : S_FINAL;
        end
      end
      S_REPORT: begin
        if (out_ch.ready) begin
          state_nxt = (idx_r < entries_used) ? S_CMP : S_FINAL;
        end
      end
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        // read data is for idx_r
        if (hit) begin
          hit_nxt   = 1'b1;
          mask_nxt  = tab_rdata[15:0];
          state_nxt = S_FINAL;
        end else if (idx_r + CW'(1) < entries_used) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_READ;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
    end
    mask_r <= mask_nxt;
    if (job_taken) begin
      job_r <= job;
    end
  end
endmodule

// ----- sv/keypad_code_matcher.sv -----
// Keypad code matcher.
// in_*  : one transaction per keypad key, badge read, table command or tick.
// out_* : result transactions; out_last marks the final result of a command.
// cfg_* : register writes (0 timeout_ticks, 1 max_digits), always ready;
//         write only while the block is idle.
// The front updates pending code, timer and table count in the accept cycle
// and pushes any result-producing work into a two-entry queue. The back
// drains the queue: a check emits a code-received report, then scans the
// table one entry at a time (registered RAM read, then compare), then
// emits the match or incorrect-code result. Single-result commands emit
// only their final result; commands with no result never enter the queue.
// in_ready drops while the queue is full; a stalled out_ready holds the
// current result and backs up the queue without losing anything.
// Add-entry and clear-table transactions also wait (in_ready low) until the
// queue is empty and the back is idle, so each check sees the table it was
// accepted against.
// Reset clears the entry count, pending code and timer, restores register
// defaults (timeout 3000, max digits 8); table contents stay undefined but
// are never read before being written.
module keypad_code_matcher #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  kcm_in_if.sink    in_ch,
  kcm_cfg_if.sink   cfg_ch,
  kcm_out_if.source out_ch
);
  import kcm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic          f_valid, q_full, b_taken;
  logic          b_busy, scan_busy;
  job_t          f_job;
  logic          tab_we;
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [55:0]   tab_wdata, tab_rdata;
  logic [CW-1:0] used;

  // Two-entry job queue between front and back.
  job_t q_mem_r [2];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;

  assign q_full    = q_cnt_r == 2'd2;
  assign scan_busy = b_busy || (q_cnt_r != 2'd0);

  kcm_front #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW)) u_front (
    .clk, .rst_n, .in_ch, .cfg_ch,
    .job_valid(f_valid), .job(f_job), .job_full(q_full), .back_busy(scan_busy),
    .tab_we, .tab_waddr, .tab_wdata, .entries_used(used)
  );

  kcm_ram #(.WIDTH(56), .DEPTH(TABLE_DEPTH)) u_table (
    .clk, .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  kcm_back #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW)) u_back (
    .clk, .rst_n, .job_valid(q_cnt_r != 2'd0), .job(q_mem_r[q_rp_r]),
    .job_taken(b_taken), .busy(b_busy), .tab_raddr, .tab_rdata, .entries_used(used),
    .out_ch
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (f_valid) begin
        q_wp_r <= ~q_wp_r;
      end
      if (b_taken) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, f_valid} - {1'b0, b_taken};
    end
    if (f_valid) begin
      q_mem_r[q_wp_r] <= f_job;
    end
  end
endmodule

// ----- sv/keypad_code_matcher_checker.sv -----
module keypad_code_matcher_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_event_kind,
  input logic       out_last,
  input logic [4:0] out_entry_count
);
  import kcm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind))
    else $error("result dropped while stalled");

  a_report_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_CODE_RX |-> !out_last)
    else $error("code report flagged last");

  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_CODE_RX |-> out_last)
    else $error("final result not flagged last");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_COUNT |-> out_entry_count <= 5'd16)
    else $error("entry count out of range");
endmodule

bind keypad_code_matcher keypad_code_matcher_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_event_kind(out_ch.event_kind), .out_last(out_ch.last),
  .out_entry_count(out_ch.entry_count)
);
